### src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Field widths, command and status codes, and the control structs that pass
// between the allocator's sub-blocks.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int LABEL_W  = 8;
  localparam int UNITS_W  = 11;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 6;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_UNLOAD = 1'b1
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_IN_USE    = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Result of a slot table lookup.
  typedef struct packed {
    logic done;
    logic hit;
    logic free_hit;
  } slot_status_t;

  // Slot table update: take a slot for a new label or drop one.
  typedef struct packed {
    logic take;
    logic drop;
  } slot_wr_t;

  // Frame bitmap write: set marks a frame used, clear marks it free.
  typedef struct packed {
    logic en;
    logic set;
  } frame_wr_t;

endpackage

### src/pfa_if.sv
// ----------------------------------------------------------------------------
// pfa_if: request and result channels of the page frame allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pfa_req_if;
  import pfa_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [LABEL_W-1:0] label;
  logic [UNITS_W-1:0] request_units;

  modport source (output valid, output command, output label, output request_units,
                  input ready);
  modport sink   (input valid, input command, input label, input request_units,
                  output ready);
endinterface

interface pfa_res_if;
  import pfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  page_index;
  logic [INDEX_W-1:0]  frame_index;
  logic                last;

  modport source (output valid, output status, output page_index, output frame_index,
                  output last, input ready);
  modport sink   (input valid, input status, input page_index, input frame_index,
                  input last, output ready);
endinterface

### src/pfa_page_div.sv
// ----------------------------------------------------------------------------
// pfa_page_div: page count of a load request
// Computes ceil(units / PAGE_UNITS) by multiplying the rounded-up numerator
// with a fixed reciprocal: the numerator is registered first, then the product.
// ----------------------------------------------------------------------------
module pfa_page_div #(
  parameter int  PAGE_UNITS = 16,
  localparam int QW = $clog2((1 << pfa_pkg::UNITS_W) - 1 + PAGE_UNITS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfa_pkg::UNITS_W-1:0] units,
  output logic                        done,
  output logic [QW-1:0]               pages
);
  import pfa_pkg::*;

  // The numerator stays below 2**QW, so a reciprocal rounded up with
  // QW + clog2(PAGE_UNITS) fraction bits gives the exact floor quotient.
  localparam int     SHIFT_L = $clog2(PAGE_UNITS);
  localparam int     SH      = QW + SHIFT_L;
  localparam int     MW      = QW + 2;
  localparam int     PW      = QW + MW;
  localparam longint RECIP   = ((longint'(1) << SH) + longint'(PAGE_UNITS) - 1) /
                               longint'(PAGE_UNITS);

  logic          busy;
  logic [QW-1:0] num;
  logic [PW-1:0] prod;

  assign prod = PW'(num) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= QW'(units) + QW'(PAGE_UNITS - 1);
    end else if (busy) begin
      pages <= QW'(prod >> SH);
    end
  end

endmodule

### src/pfa_frame_map.sv
// ----------------------------------------------------------------------------
// pfa_frame_map: frame usage bitmap
// One bit per physical frame in a synchronous memory, with the sweep that
// loads the reserved frames after reset and a running count of free frames.
// ----------------------------------------------------------------------------
module pfa_frame_map #(
  parameter int  FRAME_COUNT     = 64,
  parameter int  RESERVED_FRAMES = 4,
  localparam int FW  = $clog2(FRAME_COUNT),
  localparam int FCW = $clog2(FRAME_COUNT + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [FW-1:0]      rd_addr,
  output logic               rd_data,
  input  pfa_pkg::frame_wr_t wr,
  input  logic [FW-1:0]      wr_addr,
  output logic               ready,
  output logic [FCW-1:0]     free_count
);
  import pfa_pkg::*;

  localparam int HELD = (RESERVED_FRAMES < FRAME_COUNT) ? RESERVED_FRAMES : FRAME_COUNT;
  localparam int FREE_RESET = FRAME_COUNT - HELD;

  logic          used_mem [FRAME_COUNT];
  logic          clr_busy;
  logic [FW-1:0] clr_addr;

  assign ready = !clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy   <= 1'b1;
      clr_addr   <= '0;
      free_count <= FCW'(FREE_RESET);
    end else if (clr_busy) begin
      clr_addr <= clr_addr + FW'(1);
      if (clr_addr == FW'(FRAME_COUNT - 1)) begin
        clr_busy <= 1'b0;
      end
    end else if (wr.en) begin
      free_count <= wr.set ? free_count - FCW'(1) : free_count + FCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      used_mem[clr_addr] <= int'(clr_addr) < RESERVED_FRAMES;
    end else if (wr.en) begin
      used_mem[wr_addr] <= wr.set;
    end
    rd_data <= used_mem[rd_addr];
  end

endmodule

### src/pfa_slot_table.sv
// ----------------------------------------------------------------------------
// pfa_slot_table: process slot table
// Labels and page counts of the process slots in a synchronous memory, valid
// bits in flops, and a scan that finds the label's slot and the lowest free one.
// ----------------------------------------------------------------------------
module pfa_slot_table #(
  parameter int  MAX_PROCS = 8,
  parameter int  MAX_PAGES = 64,
  localparam int SW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int PCW = $clog2(MAX_PAGES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfa_pkg::LABEL_W-1:0] label,
  input  pfa_pkg::slot_wr_t           wr,
  input  logic [SW-1:0]               wr_slot,
  input  logic [PCW-1:0]              wr_count,
  output pfa_pkg::slot_status_t       status,
  output logic [SW-1:0]               hit_slot,
  output logic [PCW-1:0]              hit_count,
  output logic [SW-1:0]               free_slot
);
  import pfa_pkg::*;

  logic [LABEL_W-1:0] lab_mem [MAX_PROCS];
  logic [PCW-1:0]     cnt_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] slot_valid;

  logic               busy;
  logic [SW-1:0]      idx;
  logic [SW-1:0]      rd_addr;
  logic [LABEL_W-1:0] lab;
  logic [LABEL_W-1:0] rd_lab;
  logic [PCW-1:0]     rd_cnt;
  logic               match;
  logic               vacant;

  // The scan reads one slot a cycle; the data of slot idx arrives while
  // slot idx + 1 is being read.
  assign rd_addr = start ? '0 : idx + SW'(1);
  assign match   = slot_valid[idx] && (rd_lab == lab);
  assign vacant  = !slot_valid[idx];

  always_ff @(posedge clk) begin
    if (wr.take) begin
      lab_mem[wr_slot] <= lab;
      cnt_mem[wr_slot] <= wr_count;
    end
    rd_lab <= lab_mem[rd_addr];
    rd_cnt <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      status     <= '0;
      slot_valid <= '0;
    end else begin
      if (start) begin
        busy   <= 1'b1;
        idx    <= '0;
        lab    <= label;
        status <= '0;
      end else if (busy) begin
        if (match && !status.hit) begin
          status.hit <= 1'b1;
          hit_slot   <= idx;
          hit_count  <= rd_cnt;
        end
        if (vacant && !status.free_hit) begin
          status.free_hit <= 1'b1;
          free_slot       <= idx;
        end
        if (idx == SW'(MAX_PROCS - 1)) begin
          busy        <= 1'b0;
          status.done <= 1'b1;
        end else begin
          idx <= idx + SW'(1);
        end
      end
      if (wr.take) begin
        slot_valid[wr_slot] <= 1'b1;
      end
      if (wr.drop) begin
        slot_valid[wr_slot] <= 1'b0;
      end
    end
  end

endmodule

### src/page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_unit: paged physical frame allocator
// Hands out physical frames one page at a time to labeled processes and
// returns them when a process is unloaded.
// ----------------------------------------------------------------------------
// The block owns FRAME_COUNT frames, of which the lowest RESERVED_FRAMES are
// held for the operating system. A load beat (command 0) asks for
// request_units of memory: the block takes ceil(request_units / PAGE_UNITS)
// free frames, lowest first, records them in the label's page map and sends
// one result beat per page with the logical page and its frame, last set on
// the final one. A load of zero units takes a slot and sends one empty OK
// beat. A load whose label is already present, that needs more than
// MAX_PAGES pages or more frames than are free, or that finds no free slot
// out of MAX_PROCS, changes nothing and sends one error beat. An unload beat
// (command 1) frees every frame of the label and drops its slot, answering
// with one beat. Items are worked one at a time. After reset the frame
// bitmap is initialized by a sweep over every frame during which no request
// is taken. Each item first goes through the slot scan; the page count
// comes from a reciprocal multiplier alongside the scan. A load then walks
// the frame bitmap memory at one frame per cycle up to the highest frame it
// takes, waiting on a free frame while the result side stalls; an unload
// walks its page map at one page per cycle. A reply that carries no page
// passes through the reply state before it reaches the output register.
// A finished result sits in an output register, so the next request is
// taken while it waits.
// ----------------------------------------------------------------------------
module page_frame_allocator_unit #(
  parameter int FRAME_COUNT     = 64,
  parameter int PAGE_UNITS      = 16,
  parameter int RESERVED_FRAMES = 4,
  parameter int MAX_PROCS       = 8,
  parameter int MAX_PAGES       = 64
) (
  input logic       clk,
  input logic       rst,
  pfa_req_if.sink   request,
  pfa_res_if.source result
);
  import pfa_pkg::*;

  localparam int FW       = $clog2(FRAME_COUNT);
  localparam int FCW      = $clog2(FRAME_COUNT + 1);
  localparam int SW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int PCW      = $clog2(MAX_PAGES + 1);
  localparam int PM_DEPTH = MAX_PROCS * MAX_PAGES;
  localparam int PMW      = (PM_DEPTH > 1) ? $clog2(PM_DEPTH) : 1;
  localparam int QW       = $clog2((1 << UNITS_W) - 1 + PAGE_UNITS);

  // One-hot control states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ALLOC = 5'b00100,
    S_FREE  = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  state_t state, state_next;

  // Request context.
  logic           cmd, cmd_next;
  logic [PCW-1:0] pages, pages_next;
  logic [SW-1:0]  slot, slot_next;
  logic [PMW-1:0] base, base_next;
  logic [PCW-1:0] pidx, pidx_next;
  logic [FW-1:0]  faddr, faddr_next;
  status_t        reply, reply_next;

  // Output register.
  logic                out_valid, out_valid_next;
  logic                out_load;
  status_t             out_status, out_status_in;
  logic [INDEX_W-1:0]  out_page, out_page_in;
  logic [INDEX_W-1:0]  out_frame, out_frame_in;
  logic                out_last, out_last_in;
  logic                out_room;

  // Sub-block connections.
  logic                accept;
  logic                start;
  logic                div_done;
  logic [QW-1:0]       div_pages;
  logic [FW-1:0]       fr_rd_addr;
  logic                fr_rd_data;
  frame_wr_t           fr_wr;
  logic [FW-1:0]       fr_wr_addr;
  logic                fm_ready;
  logic [FCW-1:0]      fm_free;
  slot_wr_t            sl_wr;
  logic [SW-1:0]       sl_wr_slot;
  slot_status_t        sl_st;
  logic [SW-1:0]       hit_slot;
  logic [PCW-1:0]      hit_count;
  logic [SW-1:0]       free_slot;
  logic [PMW-1:0]      hit_base;
  logic [PMW-1:0]      free_base;
  logic                too_big;
  logic                alloc_last;

  // Page map memory: the frame of every page of every slot. Entries are
  // written by a load before any unload of the same slot reads them.
  logic [FW-1:0]  page_map [PM_DEPTH];
  logic           pm_we;
  logic [PMW-1:0] pm_waddr;
  logic [FW-1:0]  pm_wdata;
  logic [PMW-1:0] pm_raddr;
  logic [FW-1:0]  pm_rdata;

  pfa_page_div #(
    .PAGE_UNITS (PAGE_UNITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .units (request.request_units),
    .done  (div_done),
    .pages (div_pages)
  );

  pfa_frame_map #(
    .FRAME_COUNT     (FRAME_COUNT),
    .RESERVED_FRAMES (RESERVED_FRAMES)
  ) u_frame_map (
    .clk        (clk),
    .rst        (rst),
    .rd_addr    (fr_rd_addr),
    .rd_data    (fr_rd_data),
    .wr         (fr_wr),
    .wr_addr    (fr_wr_addr),
    .ready      (fm_ready),
    .free_count (fm_free)
  );

  pfa_slot_table #(
    .MAX_PROCS (MAX_PROCS),
    .MAX_PAGES (MAX_PAGES)
  ) u_slots (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .label     (request.label),
    .wr        (sl_wr),
    .wr_slot   (sl_wr_slot),
    .wr_count  (PCW'(div_pages)),
    .status    (sl_st),
    .hit_slot  (hit_slot),
    .hit_count (hit_count),
    .free_slot (free_slot)
  );

  always_ff @(posedge clk) begin
    if (pm_we) begin
      page_map[pm_waddr] <= pm_wdata;
    end
    pm_rdata <= page_map[pm_raddr];
  end

  assign request.ready = (state == S_IDLE) && fm_ready;
  assign accept        = request.valid && request.ready;

  assign out_room   = !out_valid || result.ready;
  assign hit_base   = PMW'(hit_slot * MAX_PAGES);
  assign free_base  = PMW'(free_slot * MAX_PAGES);
  assign too_big    = (int'(div_pages) > MAX_PAGES) || (int'(div_pages) > int'(fm_free));
  assign alloc_last = (pidx + PCW'(1)) == pages;

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    pages_next    = pages;
    slot_next     = slot;
    base_next     = base;
    pidx_next     = pidx;
    faddr_next    = faddr;
    reply_next    = reply;
    start         = 1'b0;
    fr_rd_addr    = '0;
    fr_wr         = '0;
    fr_wr_addr    = faddr;
    pm_we         = 1'b0;
    pm_waddr      = base + PMW'(pidx);
    pm_wdata      = faddr;
    pm_raddr      = base + PMW'(pidx);
    sl_wr         = '0;
    sl_wr_slot    = slot;
    out_load      = 1'b0;
    out_status_in = ST_OK;
    out_page_in   = '0;
    out_frame_in  = '0;
    out_last_in   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          start      = 1'b1;
          cmd_next   = request.command;
          state_next = S_SCAN;
        end
      end

      // Slot scan and page count are both in; decide the outcome.
      S_SCAN: begin
        if (sl_st.done && div_done) begin
          if (cmd == CMD_UNLOAD) begin
            if (!sl_st.hit) begin
              reply_next = ST_NOT_FOUND;
              state_next = S_REPLY;
            end else begin
              slot_next  = hit_slot;
              base_next  = hit_base;
              pages_next = hit_count;
              if (hit_count == '0) begin
                sl_wr.drop = 1'b1;
                sl_wr_slot = hit_slot;
                reply_next = ST_OK;
                state_next = S_REPLY;
              end else begin
                pm_raddr   = hit_base;
                pidx_next  = PCW'(1);
                state_next = S_FREE;
              end
            end
          end else begin
            priority if (sl_st.hit) begin
              reply_next = ST_IN_USE;
              state_next = S_REPLY;
            end else if (too_big) begin
              reply_next = ST_OOM;
              state_next = S_REPLY;
            end else if (!sl_st.free_hit) begin
              reply_next = ST_FULL;
              state_next = S_REPLY;
            end else begin
              sl_wr.take = 1'b1;
              sl_wr_slot = free_slot;
              slot_next  = free_slot;
              base_next  = free_base;
              pages_next = PCW'(div_pages);
              if (div_pages == '0) begin
                reply_next = ST_OK;
                state_next = S_REPLY;
              end else begin
                fr_rd_addr = '0;
                faddr_next = '0;
                pidx_next  = '0;
                state_next = S_ALLOC;
              end
            end
          end
        end
      end

      // The bitmap bit of frame faddr is on fr_rd_data. A free frame is
      // taken only when the output register can take its result; otherwise
      // the same frame is read again.
      S_ALLOC: begin
        if (!fr_rd_data) begin
          if (out_room) begin
            fr_wr.en      = 1'b1;
            fr_wr.set     = 1'b1;
            pm_we         = 1'b1;
            out_load      = 1'b1;
            out_status_in = ST_OK;
            out_page_in   = INDEX_W'(pidx);
            out_frame_in  = INDEX_W'(faddr);
            out_last_in   = alloc_last;
            pidx_next     = pidx + PCW'(1);
            faddr_next    = faddr + FW'(1);
            fr_rd_addr    = faddr + FW'(1);
            if (alloc_last) begin
              state_next = S_IDLE;
            end
          end else begin
            fr_rd_addr = faddr;
          end
        end else begin
          faddr_next = faddr + FW'(1);
          fr_rd_addr = faddr + FW'(1);
        end
      end

      // One page map entry arrives per cycle; its frame is marked free.
      S_FREE: begin
        fr_wr.en   = 1'b1;
        fr_wr.set  = 1'b0;
        fr_wr_addr = pm_rdata;
        if (pidx == pages) begin
          sl_wr.drop = 1'b1;
          reply_next = ST_OK;
          state_next = S_REPLY;
        end else begin
          pidx_next = pidx + PCW'(1);
        end
      end

      S_REPLY: begin
        if (out_room) begin
          out_load      = 1'b1;
          out_status_in = reply;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    pages <= pages_next;
    slot  <= slot_next;
    base  <= base_next;
    pidx  <= pidx_next;
    faddr <= faddr_next;
    reply <= reply_next;
    if (out_load) begin
      out_status <= out_status_in;
      out_page   <= out_page_in;
      out_frame  <= out_frame_in;
      out_last   <= out_last_in;
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.page_index  = out_page;
  assign result.frame_index = out_frame;
  assign result.last        = out_last;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the page frame allocator
// Drives load and unload beats on the request channel and predicts every
// result beat with an independent model of the frame bitmap, the slot table
// and the page maps. A scoreboard compares each result beat, field by field,
// against the oldest prediction. Both channels mostly idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pfa_pkg::*;

  // Sizes the block is built with. They are passed to the instance below, so
  // the predictor and the hardware always agree on them.
  localparam int FRAMES         = 64;
  localparam int PAGE_UNITS     = 16;
  localparam int RESERVED       = 4;
  localparam int SLOTS          = 8;
  localparam int PAGES_PER_SLOT = 64;

  // Cycles with no beat on either channel before the run is declared hung.
  // The slowest legal gap is roughly the slot scan plus a full bitmap walk
  // plus a receiver stall.
  localparam int IDLE_LIMIT     = 4000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 56;
  localparam int LABEL_CHOICES  = 12;

  // One predicted result beat.
  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] page_index;
    logic [INDEX_W-1:0] frame_index;
    logic               last;
  } alloc_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the allocator state, turns each
  // accepted request into the beats it should cause and checks result beats
  // in order against them.
  // --------------------------------------------------------------------------
  class alloc_scoreboard;
    bit                 frame_taken[FRAMES];
    bit                 slot_live[SLOTS];
    logic [LABEL_W-1:0] slot_tag[SLOTS];
    int                 slot_pages[SLOTS];
    int                 frame_of_page[SLOTS][PAGES_PER_SLOT];
    alloc_beat_t        awaited[$];
    int                 errors;
    int                 loads;
    int                 unloads;
    int                 beats;
    int                 status_hits[5];

    function new();
      for (int f = 0; f < FRAMES; f++) frame_taken[f] = (f < RESERVED);
      for (int s = 0; s < SLOTS; s++) begin
        slot_live[s]  = 1'b0;
        slot_pages[s] = 0;
      end
      for (int k = 0; k < 5; k++) status_hits[k] = 0;
      errors  = 0;
      loads   = 0;
      unloads = 0;
      beats   = 0;
    endfunction

    function int slot_of(logic [LABEL_W-1:0] lab);
      for (int s = 0; s < SLOTS; s++)
        if (slot_live[s] && slot_tag[s] == lab) return s;
      return -1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int s = 0; s < SLOTS; s++) n += slot_live[s];
      return n;
    endfunction

    // Label of the k-th occupied slot, counting from slot zero.
    function logic [LABEL_W-1:0] live_label(int k);
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_live[s]) begin
          if (k == 0) return slot_tag[s];
          k--;
        end
      end
      return '0;
    endfunction

    function void queue_beat(status_t st, int pg, int fr, bit lst);
      alloc_beat_t b;
      b.status      = st;
      b.page_index  = INDEX_W'(pg);
      b.frame_index = INDEX_W'(fr);
      b.last        = lst;
      awaited = {awaited, b};
    endfunction

    // Apply one accepted request to the model and queue its result beats.
    function void note_request(command_t cmd, logic [LABEL_W-1:0] lab,
                               logic [UNITS_W-1:0] units);
      int s;
      int pages;
      int free_frames;
      int n;
      s = slot_of(lab);
      if (cmd == CMD_UNLOAD) begin
        unloads++;
        if (s < 0) begin
          queue_beat(ST_NOT_FOUND, 0, 0, 1'b1);
          return;
        end
        for (int p = 0; p < slot_pages[s]; p++) frame_taken[frame_of_page[s][p]] = 1'b0;
        slot_live[s]  = 1'b0;
        slot_pages[s] = 0;
        queue_beat(ST_OK, 0, 0, 1'b1);
        return;
      end
      loads++;
      // Rejection order: label present, then out of memory, then no slot.
      if (s >= 0) begin
        queue_beat(ST_IN_USE, 0, 0, 1'b1);
        return;
      end
      pages = (int'(units) + PAGE_UNITS - 1) / PAGE_UNITS;
      free_frames = 0;
      for (int f = 0; f < FRAMES; f++) free_frames += !frame_taken[f];
      if (pages > PAGES_PER_SLOT || pages > free_frames) begin
        queue_beat(ST_OOM, 0, 0, 1'b1);
        return;
      end
      s = -1;
      for (int k = SLOTS - 1; k >= 0; k--) if (!slot_live[k]) s = k;
      if (s < 0) begin
        queue_beat(ST_FULL, 0, 0, 1'b1);
        return;
      end
      slot_live[s]  = 1'b1;
      slot_tag[s]   = lab;
      slot_pages[s] = pages;
      // A zero-unit load holds a slot but owns no frames.
      if (pages == 0) begin
        queue_beat(ST_OK, 0, 0, 1'b1);
        return;
      end
      n = 0;
      for (int f = 0; f < FRAMES && n < pages; f++) begin
        if (!frame_taken[f]) begin
          frame_taken[f]      = 1'b1;
          frame_of_page[s][n] = f;
          queue_beat(ST_OK, n, f, n + 1 == pages);
          n++;
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t ns] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] pg,
                      logic [INDEX_W-1:0] fr, logic lst);
      alloc_beat_t want;
      beats++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing awaited (status %0d)", st));
        return;
      end
      want = awaited.pop_front();
      status_hits[int'(want.status)]++;
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, wanted %s", st, want.status.name()));
      if (pg !== want.page_index)
        report_mismatch($sformatf("page_index %0d, wanted %0d", pg, want.page_index));
      if (fr !== want.frame_index)
        report_mismatch($sformatf("frame_index %0d, wanted %0d", fr, want.frame_index));
      if (lst !== want.last)
        report_mismatch($sformatf("last %b, wanted %b", lst, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   steady_flow;   // when set, neither side inserts idle cycles
  int   idle_cycles;
  logic [LABEL_W-1:0] label_pool[LABEL_CHOICES];
  alloc_scoreboard sb;

  pfa_req_if req_ch ();
  pfa_res_if res_ch ();

  page_frame_allocator_unit #(
    .FRAME_COUNT     (FRAMES),
    .PAGE_UNITS      (PAGE_UNITS),
    .RESERVED_FRAMES (RESERVED),
    .MAX_PROCS       (SLOTS),
    .MAX_PAGES       (PAGES_PER_SLOT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch.sink),
    .result  (res_ch.source)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Reset is held at the start and then released for good.
  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Beat monitor. Result beats are checked before a request on the same edge
  // is noted; a request can never cause a result on the edge it is accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.status, res_ch.page_index, res_ch.frame_index, res_ch.last);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(command_t'(req_ch.command), req_ch.label, req_ch.request_units);
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel. The
  // reset sweep of the frame bitmap counts here too and is far below the limit.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: before each beat, ready is held low for a random number of
  // cycles, then kept high until a beat is taken. With no stall drawn, ready
  // simply stays high across beats.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        @(negedge clk) res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Idle cycles ahead of the next request. Valid drops at the first of them
  // only, so a back-to-back request keeps valid high without a glitch.
  task automatic hold_off();
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk) req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Called at a falling edge: puts one request beat up and waits for it.
  task automatic present(command_t cmd, logic [LABEL_W-1:0] lab,
                         logic [UNITS_W-1:0] units);
    req_ch.valid         <= 1'b1;
    req_ch.command       <= cmd;
    req_ch.label         <= lab;
    req_ch.request_units <= units;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_item(command_t cmd, logic [LABEL_W-1:0] lab,
                           logic [UNITS_W-1:0] units);
    hold_off();
    @(negedge clk);
    present(cmd, lab, units);
  endtask

  // Random request. Its content is chosen at the falling edge it is driven
  // on, after the previous beat has been noted, so the model's view of which
  // labels are live is current.
  task automatic send_random();
    int live;
    int roll;
    command_t cmd;
    logic [LABEL_W-1:0] lab;
    logic [UNITS_W-1:0] units;
    hold_off();
    @(negedge clk);
    live = sb.live_count();
    roll = $urandom_range(0, 99);
    if (live == 0) cmd = CMD_LOAD;
    else if (live >= SLOTS) cmd = (roll < 70) ? CMD_UNLOAD : CMD_LOAD;
    else cmd = (roll < 55) ? CMD_LOAD : CMD_UNLOAD;
    // Labels mostly come from a small pool so that duplicates and hits on
    // unload are common; now and then any label at all.
    if ($urandom_range(0, 9) == 0) lab = LABEL_W'($urandom);
    else lab = label_pool[$urandom_range(0, LABEL_CHOICES - 1)];
    if (cmd == CMD_UNLOAD && live > 0 && $urandom_range(0, 4) != 0)
      lab = sb.live_label($urandom_range(0, live - 1));
    // Sizes stay mostly small so the pool rarely runs dry; a few large ones
    // and some beyond the per-process page limit keep the error paths busy.
    roll = $urandom_range(0, 99);
    if (cmd == CMD_UNLOAD) units = UNITS_W'($urandom);
    else if (roll < 8)     units = '0;
    else if (roll < 78)    units = UNITS_W'($urandom_range(1, 160));
    else if (roll < 93)    units = UNITS_W'($urandom_range(161, 960));
    else                   units = UNITS_W'($urandom_range(961, 2047));
    present(cmd, lab, units);
  endtask

  // Stop sending and let every awaited result beat arrive.
  task automatic drain();
    @(negedge clk) req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [LABEL_W-1:0] fill_labels[5];
    logic [LABEL_W-1:0] gone_labels[8];
    sb = new();
    steady_flow          = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.command       = CMD_LOAD;
    req_ch.label         = '0;
    req_ch.request_units = '0;
    fill_labels = '{8'h10, 8'h11, 8'h12, 8'h13, 8'h14};
    gone_labels = '{8'h00, 8'h01, 8'hAA, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14};
    while (rst) @(negedge clk);

    // Directed part. Unloading from an empty table finds nothing; a zero-unit
    // load takes a slot with no frames; then a one-page load, a duplicate
    // label, a two-page load, a request over the per-process page limit and
    // one for more frames than are free.
    send_item(CMD_UNLOAD, 8'h05, 11'h7FF);
    send_item(CMD_LOAD,   8'h00, 11'd0);
    send_item(CMD_LOAD,   8'hFF, 11'd1);
    send_item(CMD_LOAD,   8'hFF, 11'd16);
    send_item(CMD_LOAD,   8'h01, 11'd17);
    send_item(CMD_LOAD,   8'h02, 11'd2047);
    send_item(CMD_LOAD,   8'h03, 11'd1024);
    // A freed frame is handed out again, lowest first.
    send_item(CMD_UNLOAD, 8'hFF, 11'd0);
    send_item(CMD_LOAD,   8'hAA, 11'd16);
    // Fill every slot, then hit the full table. Running short of memory and
    // a held label are both reported ahead of a full table.
    foreach (fill_labels[k]) send_item(CMD_LOAD, fill_labels[k], 11'd16);
    send_item(CMD_LOAD, 8'h55, 11'd16);
    send_item(CMD_LOAD, 8'h55, 11'd2000);
    send_item(CMD_LOAD, 8'h00, 11'd5);
    foreach (gone_labels[k]) send_item(CMD_UNLOAD, gone_labels[k], UNITS_W'($urandom));
    // With the table empty, one load takes every free frame: the longest
    // burst of result beats there is.
    send_item(CMD_LOAD,   8'h77, 11'd960);
    send_item(CMD_UNLOAD, 8'h77, 11'd0);
    // Hold the sender until the block has answered everything.
    drain();

    // Random part, in phases. Two phases run with no idling on either side;
    // each phase ends with the sender waiting for all results.
    for (int ph = 0; ph < PHASES; ph++) begin
      steady_flow = (ph == 2 || ph == 4);
      foreach (label_pool[k]) label_pool[k] = LABEL_W'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      drain();
    end

    steady_flow = 1'b0;
    // Any stray beat in this window shows up as unexpected.
    repeat (100) @(negedge clk);

    $display("Checked %0d result beats from %0d loads and %0d unloads.",
             sb.beats, sb.loads, sb.unloads);
    $display("Status mix: ok %0d, out of memory %0d, not found %0d, in use %0d, full %0d.",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) $display("%0d result beats never arrived", sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
